// File: hw/rtl/hfts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the height-field triangle sampler.
// No dependencies; the other files except hfts_fifo refer to it by scoped names.
package hfts_pkg;

   // Grid store and fixed-point layout
   localparam int STORE_ADDR_BITS = 16;
   localparam int FRAC_BITS       = 24;
   localparam logic [FRAC_BITS-1:0] ROUND_HALF = 24'h800000;

   // Queue depths, as address bits
   localparam int QUEUE_ADDR_BITS  = 2;
   localparam int RESULT_ADDR_BITS = 2;

   // Configuration register indexes
   localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
   localparam logic [2:0] REG_GRID_DEPTH    = 3'd1;
   localparam logic [2:0] REG_INVERSE_SCALE = 3'd2;
   localparam logic [2:0] REG_OFFSET_X      = 3'd3;
   localparam logic [2:0] REG_OFFSET_Z      = 3'd4;
   localparam logic [2:0] REG_HEIGHT_GAIN   = 3'd5;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Corner of the cell read in the current cycle; also the sequencer state
   typedef enum logic [1:0] {
      CORNER_00 = 2'd0,
      CORNER_10 = 2'd1,
      CORNER_01 = 2'd2,
      CORNER_11 = 2'd3
   } corner_type;

   typedef struct packed {
      op_type                     op;
      logic                       in_range;
      logic [STORE_ADDR_BITS-1:0] addr;
      logic signed [15:0]         sample;
      logic [FRAC_BITS-1:0]       frac_u;
      logic [FRAC_BITS-1:0]       frac_v;
   } queue_entry_type;

   typedef struct packed {
      logic signed [32:0] height;
      logic               in_range;
   } result_type;

endpackage

// File: hw/rtl/hfts_fifo.sv
`timescale 1ns / 1ps
// Small register-based FIFO, used between front and back and on the result side.
// Depends on nothing; width and depth come from parameters.
module hfts_fifo #(
   parameter int WIDTH     = 34,
   parameter int ADDR_BITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] data_i,
   input  logic             pop_i,
   output logic [WIDTH-1:0] data_o,
   output logic             full_o,
   output logic             empty_o
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full_o  = (count_ff == (ADDR_BITS + 1)'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign data_o  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + ADDR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + ADDR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (ADDR_BITS + 1)'(do_push) - (ADDR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule

// File: hw/rtl/hfts_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, maps query positions to grid cells and fractions,
// checks range and forms store addresses. Depends on hfts_pkg.
module hfts_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_i,
   output logic                      full_o,
   input  logic                      cmd_i,
   input  logic [15:0]               cell_index_i,
   input  logic signed [15:0]        sample_value_i,
   input  logic signed [23:0]        pos_x_i,
   input  logic signed [23:0]        pos_z_i,
   input  logic [8:0]                width_i,
   input  logic [8:0]                depth_i,
   input  logic [23:0]               inverse_scale_i,
   input  logic signed [23:0]        offset_x_i,
   input  logic signed [23:0]        offset_z_i,
   output logic                      entry_push_o,
   output hfts_pkg::queue_entry_type entry_o,
   input  logic                      queue_full_i
);

   typedef struct packed {
      hfts_pkg::op_type   op;
      logic [15:0]        cell_index;
      logic signed [15:0] sample;
      logic [24:0]        sum_x;
      logic [24:0]        sum_z;
   } sum_stage_type;

   typedef struct packed {
      hfts_pkg::op_type   op;
      logic [15:0]        cell_index;
      logic signed [15:0] sample;
      logic [48:0]        grid_x;
      logic [48:0]        grid_z;
   } grid_stage_type;

   typedef struct packed {
      hfts_pkg::op_type   op;
      logic [15:0]        cell_index;
      logic signed [15:0] sample;
      logic               in_range;
      logic [8:0]         col;
      logic [8:0]         row;
      logic [23:0]        frac_u;
      logic [23:0]        frac_v;
   } cell_stage_type;

   sum_stage_type             s1_ff, s1_in;
   grid_stage_type            s2_ff, s2_in;
   cell_stage_type            s3_ff, s3_in;
   hfts_pkg::queue_entry_type s4_ff, s4_in;
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                      rdy1, rdy2, rdy3, rdy4;
   logic signed [49:0]        prod_x, prod_z;
   logic                      col_ok, row_ok;
   logic [17:0]               row_base;

   // Stage ready chain: a stage takes new data when empty or when it moves on
   always_comb begin
      rdy4         = !s4_valid_ff || !queue_full_i;
      rdy3         = !s3_valid_ff || rdy4;
      rdy2         = !s2_valid_ff || rdy3;
      rdy1         = !s1_valid_ff || rdy2;
      full_o       = !rdy1;
      entry_push_o = s4_valid_ff && !queue_full_i;
      entry_o      = s4_ff;
   end

   // Stage 1: add offsets
   always_comb begin
      s1_in.op         = hfts_pkg::op_type'(cmd_i);
      s1_in.cell_index = cell_index_i;
      s1_in.sample     = sample_value_i;
      s1_in.sum_x      = {pos_x_i[23], pos_x_i} + {offset_x_i[23], offset_x_i};
      s1_in.sum_z      = {pos_z_i[23], pos_z_i} + {offset_z_i[23], offset_z_i};
   end

   // Stage 2: scale into grid units, 24 fraction bits
   always_comb begin
      prod_x           = $signed(s1_ff.sum_x) * $signed({1'b0, inverse_scale_i});
      prod_z           = $signed(s1_ff.sum_z) * $signed({1'b0, inverse_scale_i});
      s2_in.op         = s1_ff.op;
      s2_in.cell_index = s1_ff.cell_index;
      s2_in.sample     = s1_ff.sample;
      s2_in.grid_x     = prod_x[48:0];
      s2_in.grid_z     = prod_z[48:0];
   end

   // Stage 3: split into cell and fraction, check that the cell and its
   // right and lower neighbours are inside the grid
   always_comb begin
      col_ok = !s2_ff.grid_x[48] && (s2_ff.grid_x[47:33] == '0)
               && (({1'b0, s2_ff.grid_x[32:24]} + 10'd1) < {1'b0, width_i});
      row_ok = !s2_ff.grid_z[48] && (s2_ff.grid_z[47:33] == '0)
               && (({1'b0, s2_ff.grid_z[32:24]} + 10'd1) < {1'b0, depth_i});
      s3_in.op         = s2_ff.op;
      s3_in.cell_index = s2_ff.cell_index;
      s3_in.sample     = s2_ff.sample;
      s3_in.in_range   = col_ok && row_ok;
      s3_in.col        = s2_ff.grid_x[32:24];
      s3_in.row        = s2_ff.grid_z[32:24];
      s3_in.frac_u     = s2_ff.grid_x[23:0];
      s3_in.frac_v     = s2_ff.grid_z[23:0];
   end

   // Stage 4: load index, or row-major upper-left corner address (wrapped)
   always_comb begin
      row_base       = s3_ff.row * width_i;
      s4_in.op       = s3_ff.op;
      s4_in.in_range = (s3_ff.op == hfts_pkg::OP_QUERY) && s3_ff.in_range;
      s4_in.addr     = (s3_ff.op == hfts_pkg::OP_LOAD) ? s3_ff.cell_index
                       : row_base[15:0] + {7'b0, s3_ff.col};
      s4_in.sample   = s3_ff.sample;
      s4_in.frac_u   = s3_ff.frac_u;
      s4_in.frac_v   = s3_ff.frac_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= push_i;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) s3_ff <= s3_in;
      if (rdy4) s4_ff <= s4_in;
   end

endmodule

// File: hw/rtl/hfts_back.sv
`timescale 1ns / 1ps
// Back part: grid store, corner read sequencer, triangle interpolation and
// gain scaling pipeline with result credits. Depends on hfts_pkg.
module hfts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty_i,
   input  hfts_pkg::queue_entry_type head_i,
   output logic                      queue_pop_o,
   input  logic [8:0]                width_i,
   input  logic [15:0]               height_gain_i,
   input  logic                      result_pop_i,
   output logic                      result_push_o,
   output hfts_pkg::result_type      result_o
);

   localparam int CREDIT_BITS = hfts_pkg::RESULT_ADDR_BITS + 1;
   localparam logic [CREDIT_BITS-1:0] CREDIT_MAX =
      CREDIT_BITS'(1 << hfts_pkg::RESULT_ADDR_BITS);
   localparam int STORE_DEPTH = 1 << hfts_pkg::STORE_ADDR_BITS;

   typedef struct packed {
      hfts_pkg::corner_type corner;
      logic                 last;
      logic                 in_range;
      logic [23:0]          frac_u;
      logic [23:0]          frac_v;
   } tag_type;

   typedef struct packed {
      logic               in_range;
      logic [16:0]        diff_a;
      logic [16:0]        diff_b;
      logic signed [15:0] h00;
      logic [23:0]        frac_u;
      logic [23:0]        frac_v;
   } slope_stage_type;

   typedef struct packed {
      logic               in_range;
      logic signed [15:0] h00;
      logic [40:0]        prod_a;
      logic [40:0]        prod_b;
   } product_stage_type;

   typedef struct packed {
      logic        in_range;
      logic [40:0] raw;
   } raw_stage_type;

   typedef struct packed {
      logic        in_range;
      logic [41:0] gain_hi;
      logic [31:0] gain_lo;
   } gain_stage_type;

   logic signed [15:0]   store_mem [STORE_DEPTH];
   logic signed [15:0]   rd_data_ff;
   logic signed [15:0]   h00_ff, h10_ff, h01_ff;
   hfts_pkg::corner_type seq_ff, seq_in;
   tag_type              tag_ff, tag_in;
   logic                 tag_valid_ff, tag_valid_in;
   logic [CREDIT_BITS-1:0] credit_ff, credit_in;
   logic                 take_credit, credit_ok;
   logic                 mem_we, mem_re;
   logic [15:0]          mem_addr;

   slope_stage_type      e1_ff, e1_in;
   product_stage_type    e2_ff, e2_in;
   raw_stage_type        e3_ff, e3_in;
   gain_stage_type       e4_ff, e4_in;
   logic                 e1_valid_ff, e2_valid_ff, e3_valid_ff, e4_valid_ff;
   logic                 upper;
   logic [16:0]          h00_x, h10_x, h01_x, h11_x;
   logic signed [41:0]   prod_a_full, prod_b_full, gain_hi_full;
   logic [57:0]          scaled_sum;
   logic [33:0]          scaled;

   // Sequencer: a load writes the store; an in-range query with a credit reads
   // its four corners on consecutive cycles and leaves the queue on the last one
   always_comb begin
      seq_in          = seq_ff;
      queue_pop_o     = 1'b0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_addr        = head_i.addr;
      take_credit     = 1'b0;
      credit_ok       = (credit_ff < CREDIT_MAX);
      tag_valid_in    = 1'b0;
      tag_in.corner   = seq_ff;
      tag_in.last     = 1'b0;
      tag_in.in_range = head_i.in_range;
      tag_in.frac_u   = head_i.frac_u;
      tag_in.frac_v   = head_i.frac_v;
      unique case (seq_ff)
         hfts_pkg::CORNER_00: begin
            if (!queue_empty_i) begin
               if (head_i.op == hfts_pkg::OP_LOAD) begin
                  mem_we      = 1'b1;
                  queue_pop_o = 1'b1;
               end else if (credit_ok) begin
                  take_credit  = 1'b1;
                  tag_valid_in = 1'b1;
                  if (head_i.in_range) begin
                     mem_re = 1'b1;
                     seq_in = hfts_pkg::CORNER_10;
                  end else begin
                     // out of range: no reads, straight to the result pipeline
                     queue_pop_o   = 1'b1;
                     tag_in.corner = hfts_pkg::CORNER_11;
                     tag_in.last   = 1'b1;
                  end
               end
            end
         end
         hfts_pkg::CORNER_10: begin
            mem_re       = 1'b1;
            mem_addr     = head_i.addr + 16'd1;
            tag_valid_in = 1'b1;
            seq_in       = hfts_pkg::CORNER_01;
         end
         hfts_pkg::CORNER_01: begin
            mem_re       = 1'b1;
            mem_addr     = head_i.addr + {7'b0, width_i};
            tag_valid_in = 1'b1;
            seq_in       = hfts_pkg::CORNER_11;
         end
         hfts_pkg::CORNER_11: begin
            mem_re       = 1'b1;
            mem_addr     = head_i.addr + {7'b0, width_i} + 16'd1;
            tag_valid_in = 1'b1;
            tag_in.last  = 1'b1;
            queue_pop_o  = 1'b1;
            seq_in       = hfts_pkg::CORNER_00;
         end
      endcase
      credit_in = credit_ff + CREDIT_BITS'(take_credit) - CREDIT_BITS'(result_pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= hfts_pkg::CORNER_00;
         tag_valid_ff <= 1'b0;
         credit_ff    <= '0;
      end else begin
         seq_ff       <= seq_in;
         tag_valid_ff <= tag_valid_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   // Single-port grid store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= head_i.sample;
      end else if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // Hold the first three corners until the fourth arrives
   always_ff @(posedge clock) begin
      if (tag_valid_ff) begin
         unique case (tag_ff.corner)
            hfts_pkg::CORNER_00: h00_ff <= rd_data_ff;
            hfts_pkg::CORNER_10: h10_ff <= rd_data_ff;
            hfts_pkg::CORNER_01: h01_ff <= rd_data_ff;
            hfts_pkg::CORNER_11: begin
            end
         endcase
      end
   end

   // E1: pick the triangle and form the two slopes
   always_comb begin
      h00_x = {h00_ff[15], h00_ff};
      h10_x = {h10_ff[15], h10_ff};
      h01_x = {h01_ff[15], h01_ff};
      h11_x = {rd_data_ff[15], rd_data_ff};
      upper = (tag_ff.frac_u > tag_ff.frac_v);
      e1_in.in_range = tag_ff.in_range;
      e1_in.diff_a   = upper ? h10_x - h00_x : h11_x - h01_x;
      e1_in.diff_b   = upper ? h11_x - h10_x : h01_x - h00_x;
      e1_in.h00      = h00_ff;
      e1_in.frac_u   = tag_ff.frac_u;
      e1_in.frac_v   = tag_ff.frac_v;
   end

   // E2: slope times fraction
   always_comb begin
      prod_a_full    = $signed(e1_ff.diff_a) * $signed({1'b0, e1_ff.frac_u});
      prod_b_full    = $signed(e1_ff.diff_b) * $signed({1'b0, e1_ff.frac_v});
      e2_in.in_range = e1_ff.in_range;
      e2_in.h00      = e1_ff.h00;
      e2_in.prod_a   = prod_a_full[40:0];
      e2_in.prod_b   = prod_b_full[40:0];
   end

   // E3: raw height with 24 fraction bits
   always_comb begin
      e3_in.in_range = e2_ff.in_range;
      e3_in.raw      = {e2_ff.h00[15], e2_ff.h00, 24'b0} + e2_ff.prod_a + e2_ff.prod_b;
   end

   // E4: gain, split into high and low partial products
   always_comb begin
      gain_hi_full    = $signed(e3_ff.raw[40:16]) * $signed({1'b0, height_gain_i});
      e4_in.in_range  = e3_ff.in_range;
      e4_in.gain_hi   = gain_hi_full;
      e4_in.gain_lo   = e3_ff.raw[15:0] * height_gain_i;
   end

   // E5: recombine, round half up, drop 24 fraction bits, saturate, zero if out of range
   always_comb begin
      scaled_sum = {e4_ff.gain_hi, 16'b0} + {26'b0, e4_ff.gain_lo}
                   + {34'b0, hfts_pkg::ROUND_HALF};
      scaled     = scaled_sum[57:24];
      result_o.in_range = e4_ff.in_range;
      if (!e4_ff.in_range) begin
         result_o.height = '0;
      end else if (scaled[33] != scaled[32]) begin
         result_o.height = scaled[33] ? {1'b1, 32'b0} : {1'b0, {32{1'b1}}};
      end else begin
         result_o.height = scaled[32:0];
      end
      result_push_o = e4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= tag_valid_ff && tag_ff.last;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
         e4_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      e3_ff <= e3_in;
      e4_ff <= e4_in;
   end

`ifndef NO_ASSERTIONS
   credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_MAX)
      else $error("result credits exceed the result queue depth");

   head_held: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != hfts_pkg::CORNER_00) |-> !queue_empty_i)
      else $error("corner reads in progress without a queue head");

   pop_needs_credit: assert property (@(posedge clock) disable iff (reset)
      result_pop_i |-> (credit_ff != '0))
      else $error("result transfer without an outstanding credit");

   last_read_order: assert property (@(posedge clock) disable iff (reset)
      (tag_valid_ff && tag_ff.last && tag_ff.in_range)
      |-> ($past(seq_ff) == hfts_pkg::CORNER_11))
      else $error("in-range query launched before its fourth corner read");
`endif

endmodule

// File: hw/rtl/height_field_triangle_sampler.sv
`timescale 1ns / 1ps
// Top level of the height-field triangle sampler: configuration registers,
// front part, middle queue, back part and result queue.
// Depends on hfts_pkg, hfts_fifo, hfts_front and hfts_back.
//
//   Channel   Ports                                      Transfer when
//   --------  -----------------------------------------  -------------------------
//   request   push, full, req_cmd .. req_pos_z           push high, full low
//   response  empty, pop, rsp_height_out, rsp_in_range   pop high, empty low
//   config    psel, penable, pwrite, paddr, pwdata,      psel, penable, pwrite,
//             prdata, pready                             pready all high
//
// An in-range query holds the back part while its four corner heights are read
// from one single-port store, one read per cycle; a load only writes the store.
// A request passes to the response through 4 front stages, the middle queue,
// the four corner reads, interpolation and scaling steps E1 to E5, and the result queue.
// Reset clears control state only; the grid store holds garbage until loaded.
// Either side may stall on its own: the middle queue absorbs a stalled back,
// and the result queue lets new requests enter while results wait.
module height_field_triangle_sampler #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               push,
   output logic               full,
   input  logic               req_cmd,
   input  logic [15:0]        req_cell_index,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_z,
   // response channel
   output logic               empty,
   input  logic               pop,
   output logic signed [32:0] rsp_height_out,
   output logic               rsp_in_range,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Configuration registers
   logic [8:0]         grid_width_ff, grid_depth_ff;
   logic [23:0]        inverse_scale_ff;
   logic signed [23:0] offset_x_ff, offset_z_ff;
   logic [15:0]        height_gain_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   // Grid size in use, limited to what the design was built for
   logic [8:0]         width_used, depth_used;

   // Front to middle queue
   logic                      entry_push;
   hfts_pkg::queue_entry_type entry;
   logic                      queue_full, queue_empty, queue_pop;
   hfts_pkg::queue_entry_type queue_head;

   // Back to result queue
   logic                      result_push, result_taken;
   hfts_pkg::result_type      result_in, result_out;
   logic                      result_full;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   // Accept register writes; writes to unused addresses are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff    <= 9'd256;
         grid_depth_ff    <= 9'd256;
         inverse_scale_ff <= 24'd65536;
         offset_x_ff      <= '0;
         offset_z_ff      <= '0;
         height_gain_ff   <= 16'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            hfts_pkg::REG_GRID_WIDTH:    grid_width_ff    <= pwdata[8:0];
            hfts_pkg::REG_GRID_DEPTH:    grid_depth_ff    <= pwdata[8:0];
            hfts_pkg::REG_INVERSE_SCALE: inverse_scale_ff <= pwdata[23:0];
            hfts_pkg::REG_OFFSET_X:      offset_x_ff      <= pwdata[23:0];
            hfts_pkg::REG_OFFSET_Z:      offset_z_ff      <= pwdata[23:0];
            hfts_pkg::REG_HEIGHT_GAIN:   height_gain_ff   <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read back raw register bits, zero-extended
   always_comb begin
      unique case (csr_index)
         hfts_pkg::REG_GRID_WIDTH:    prdata = {23'b0, grid_width_ff};
         hfts_pkg::REG_GRID_DEPTH:    prdata = {23'b0, grid_depth_ff};
         hfts_pkg::REG_INVERSE_SCALE: prdata = {8'b0, inverse_scale_ff};
         hfts_pkg::REG_OFFSET_X:      prdata = {8'b0, offset_x_ff};
         hfts_pkg::REG_OFFSET_Z:      prdata = {8'b0, offset_z_ff};
         hfts_pkg::REG_HEIGHT_GAIN:   prdata = {16'b0, height_gain_ff};
         default:                     prdata = '0;
      endcase
   end

   // Clamp the configured grid to the built maximum
   assign width_used = ({23'b0, grid_width_ff} > 32'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                       : grid_width_ff;
   assign depth_used = ({23'b0, grid_depth_ff} > 32'(MAX_ROWS)) ? 9'(MAX_ROWS)
                       : grid_depth_ff;

   // Front: offset, scale, classify, address
   hfts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push_i          (push),
      .full_o          (full),
      .cmd_i           (req_cmd),
      .cell_index_i    (req_cell_index),
      .sample_value_i  (req_sample_value),
      .pos_x_i         (req_pos_x),
      .pos_z_i         (req_pos_z),
      .width_i         (width_used),
      .depth_i         (depth_used),
      .inverse_scale_i (inverse_scale_ff),
      .offset_x_i      (offset_x_ff),
      .offset_z_i      (offset_z_ff),
      .entry_push_o    (entry_push),
      .entry_o         (entry),
      .queue_full_i    (queue_full)
   );

   // Middle queue: decouple the front from the store sequencer
   hfts_fifo #(
      .WIDTH     ($bits(hfts_pkg::queue_entry_type)),
      .ADDR_BITS (hfts_pkg::QUEUE_ADDR_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (entry_push),
      .data_i  (entry),
      .pop_i   (queue_pop),
      .data_o  (queue_head),
      .full_o  (queue_full),
      .empty_o (queue_empty)
   );

   // Back: store, corner reads, interpolation, gain
   hfts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty_i (queue_empty),
      .head_i        (queue_head),
      .queue_pop_o   (queue_pop),
      .width_i       (width_used),
      .height_gain_i (height_gain_ff),
      .result_pop_i  (result_taken),
      .result_push_o (result_push),
      .result_o      (result_in)
   );

   // Result queue: the back only starts a query when a slot is reserved here
   assign result_taken = pop && !empty;

   hfts_fifo #(
      .WIDTH     ($bits(hfts_pkg::result_type)),
      .ADDR_BITS (hfts_pkg::RESULT_ADDR_BITS)
   ) u_results (
      .clock   (clock),
      .reset   (reset),
      .push_i  (result_push),
      .data_i  (result_in),
      .pop_i   (result_taken),
      .data_o  (result_out),
      .full_o  (result_full),
      .empty_o (empty)
   );

   assign rsp_height_out = result_out.height;
   assign rsp_in_range   = result_out.in_range;

`ifndef NO_ASSERTIONS
   result_room: assert property (@(posedge clock) disable iff (reset)
      result_push |-> !result_full)
      else $error("result written into a full result queue");

   queue_room: assert property (@(posedge clock) disable iff (reset)
      entry_push |-> !queue_full)
      else $error("front pushed into a full middle queue");

   pop_from_filled: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("back took an item from an empty middle queue");
`endif

endmodule
